// ----- rtl/rgbconv_pkg.sv -----
package rgbconv_pkg;

  localparam int PIX_W      = 8;
  localparam int NUM_CH     = 3;
  localparam int PX_W       = NUM_CH * PIX_W;
  localparam int COEF_W     = 8;
  localparam int PROD_W     = PIX_W + COEF_W + 1;
  localparam int SUM_W      = 21;
  localparam int MAX_K      = 5;
  localparam int CFG_ROW_W  = 40;
  localparam int CFG_IMG_W_W = 11;
  localparam int CFG_IMG_H_W = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 40;
  localparam int SAT_MAX    = 255;

  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_WIDTH  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_HEIGHT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_COEF0  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_COEF1  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_COEF2  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_COEF3  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_COEF4  = 3'd6;

  localparam logic [CFG_IMG_W_W-1:0] RST_IMG_W = 11'd640;
  localparam logic [CFG_IMG_H_W-1:0] RST_IMG_H = 16'd480;
  localparam logic [CFG_ROW_W-1:0]   RST_COEF0 = 40'd65280;
  localparam logic [CFG_ROW_W-1:0]   RST_COEF1 = 40'd16712959;
  localparam logic [CFG_ROW_W-1:0]   RST_COEF2 = 40'd65280;
  localparam logic [CFG_ROW_W-1:0]   RST_COEF3 = 40'd0;
  localparam logic [CFG_ROW_W-1:0]   RST_COEF4 = 40'd0;

  typedef logic [PX_W-1:0] pixel_t;

  typedef struct packed {
    logic valid;
    logic last;
  } rgbconv_tag_t;

endpackage

// ----- rtl/rgbconv_line_buf.sv -----
module rgbconv_line_buf #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 48
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q_r;
  logic [DATA_W-1:0] fwd_data_r;
  logic              fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r     <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // same-entry read and write in one cycle: take the new data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (rd_addr == wr_addr);
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rd_q_r;

`ifndef NO_ASSERTIONS
  a_fwd_on_collision: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en && wr_en && (rd_addr == wr_addr) |=> fwd_r)
    else $error("line store collision not forwarded");

  a_no_fwd_without_write: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en && !wr_en |=> !fwd_r)
    else $error("forward taken without a write");
`endif

endmodule

// ----- rtl/rgbconv_mac.sv -----
module rgbconv_mac import rgbconv_pkg::*; #(
  parameter int KERNEL_SIZE = 3
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       en,
  input  rgbconv_tag_t                               tag_in,
  input  logic [KERNEL_SIZE*KERNEL_SIZE*PX_W-1:0]    win,
  input  logic [MAX_K*CFG_ROW_W-1:0]                 coef,
  output logic                                       out_valid,
  output logic                                       out_last,
  output logic signed [SUM_W-1:0]                    sum_ch0,
  output logic signed [SUM_W-1:0]                    sum_ch1,
  output logic signed [SUM_W-1:0]                    sum_ch2,
  output logic [PIX_W-1:0]                           sat_ch0,
  output logic [PIX_W-1:0]                           sat_ch1,
  output logic [PIX_W-1:0]                           sat_ch2
);

  logic signed [PROD_W-1:0] prod_nxt [NUM_CH][KERNEL_SIZE][KERNEL_SIZE];
  logic signed [PROD_W-1:0] prod_r   [NUM_CH][KERNEL_SIZE][KERNEL_SIZE];
  logic signed [SUM_W-1:0]  row_nxt  [NUM_CH][KERNEL_SIZE];
  logic signed [SUM_W-1:0]  row_r    [NUM_CH][KERNEL_SIZE];
  logic signed [SUM_W-1:0]  tot_nxt  [NUM_CH];
  logic [PIX_W-1:0]         sat_nxt  [NUM_CH];
  logic signed [SUM_W-1:0]  sum_r    [NUM_CH];
  logic [PIX_W-1:0]         sat_r    [NUM_CH];
  rgbconv_tag_t             tag_a_r;
  rgbconv_tag_t             tag_b_r;
  rgbconv_tag_t             tag_o_r;

  always_comb begin
    logic [PIX_W-1:0]         pix;
    logic signed [COEF_W-1:0] cv;
    for (int c = 0; c < NUM_CH; c++) begin
      for (int m = 0; m < KERNEL_SIZE; m++) begin
        for (int n = 0; n < KERNEL_SIZE; n++) begin
          pix = win[(m*KERNEL_SIZE+n)*PX_W + c*PIX_W +: PIX_W];
          cv  = coef[m*CFG_ROW_W + n*COEF_W +: COEF_W];
          prod_nxt[c][m][n] = $signed({1'b0, pix}) * cv;
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      for (int m = 0; m < KERNEL_SIZE; m++) begin
        row_nxt[c][m] = '0;
        for (int n = 0; n < KERNEL_SIZE; n++) begin
          row_nxt[c][m] = row_nxt[c][m] + SUM_W'(prod_r[c][m][n]);
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      tot_nxt[c] = '0;
      for (int m = 0; m < KERNEL_SIZE; m++) begin
        tot_nxt[c] = tot_nxt[c] + row_r[c][m];
      end
      if (tot_nxt[c] < 0) begin
        sat_nxt[c] = '0;
      end else if (tot_nxt[c] > SUM_W'(SAT_MAX)) begin
        sat_nxt[c] = PIX_W'(SAT_MAX);
      end else begin
        sat_nxt[c] = tot_nxt[c][PIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      row_r  <= row_nxt;
      sum_r  <= tot_nxt;
      sat_r  <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
      tag_b_r <= '0;
      tag_o_r <= '0;
    end else if (en) begin
      tag_a_r <= tag_in;
      tag_b_r <= tag_a_r;
      tag_o_r <= tag_b_r;
    end
  end

  assign out_valid = tag_o_r.valid;
  assign out_last  = tag_o_r.last;
  assign sum_ch0   = sum_r[0];
  assign sum_ch1   = sum_r[1];
  assign sum_ch2   = sum_r[2];
  assign sat_ch0   = sat_r[0];
  assign sat_ch1   = sat_r[1];
  assign sat_ch2   = sat_r[2];

endmodule

// ----- rtl/rgb_image_convolution_top.sv -----
// Streaming valid-region KERNEL_SIZE x KERNEL_SIZE convolution of 8-bit RGB pixels in raster
// order: one pixel request is taken every clock unless the result output stalls, and results
// leave one per clock likewise, set by the single read and single write port of the line
// store (one entry per column holding the last KERNEL_SIZE-1 lines) and a pipeline of
// products, row sums and totals. A W x H frame gives (W-K+1) x (H-K+1) results, the last
// flagged by out_last_of_frame. The user must write configuration only while no request is
// in flight; the block does not enforce it. A width of zero counts as one, above MAX_WIDTH
// as MAX_WIDTH, and a height of zero as one. The line store needs no clearing after reset.
module rgb_image_convolution_top import rgbconv_pkg::*; #(
  parameter int KERNEL_SIZE = 3,
  parameter int MAX_WIDTH   = 1024
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [PIX_W-1:0]        in_pixel_ch0,
  input  logic [PIX_W-1:0]        in_pixel_ch1,
  input  logic [PIX_W-1:0]        in_pixel_ch2,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [SUM_W-1:0] out_sum_ch0,
  output logic signed [SUM_W-1:0] out_sum_ch1,
  output logic signed [SUM_W-1:0] out_sum_ch2,
  output logic [PIX_W-1:0]        out_sat_ch0,
  output logic [PIX_W-1:0]        out_sat_ch1,
  output logic [PIX_W-1:0]        out_sat_ch2,
  output logic                    out_last_of_frame,
  input  logic                    cfg_we,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int NUM_LINES = KERNEL_SIZE - 1;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int EW        = (CFG_IMG_W_W > $clog2(MAX_WIDTH + 1)) ?
                             CFG_IMG_W_W : $clog2(MAX_WIDTH + 1);
  localparam int LB_W      = NUM_LINES * PX_W;
  localparam int WIN_W     = KERNEL_SIZE * KERNEL_SIZE * PX_W;

  logic [CFG_IMG_W_W-1:0]       img_w_r;
  logic [CFG_IMG_H_W-1:0]       img_h_r;
  logic [MAX_K*CFG_ROW_W-1:0]   coef_r;

  logic [EW-1:0]                w_eff;
  logic [CFG_IMG_H_W-1:0]       h_eff;
  logic [EW-1:0]                col_ext;
  logic [EW-1:0]                col_inc;
  logic [CFG_IMG_H_W:0]         row_inc;
  logic [COL_W-1:0]             col_r;
  logic [COL_W-1:0]             col_nxt;
  logic [CFG_IMG_H_W-1:0]       row_r;
  logic [CFG_IMG_H_W-1:0]       row_nxt;
  logic                         emit;
  logic                         last;

  logic                         en;
  logic                         accept;
  logic                         s1_adv;
  logic                         s1_valid_r;
  logic                         s1_emit_r;
  logic                         s1_last_r;
  pixel_t                       s1_px_r;
  logic [COL_W-1:0]             s1_col_r;
  rgbconv_tag_t                 s2_tag_r;

  logic [LB_W-1:0]              lb_rd_data;
  logic [LB_W-1:0]              lb_wr_data;
  pixel_t                       newcol [KERNEL_SIZE];
  pixel_t                       win_r  [KERNEL_SIZE][KERNEL_SIZE];
  logic [WIN_W-1:0]             win_flat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r <= RST_IMG_W;
      img_h_r <= RST_IMG_H;
      coef_r  <= {RST_COEF4, RST_COEF3, RST_COEF2, RST_COEF1, RST_COEF0};
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_IDX_WIDTH:  img_w_r <= cfg_wdata[CFG_IMG_W_W-1:0];
        CFG_IDX_HEIGHT: img_h_r <= cfg_wdata[CFG_IMG_H_W-1:0];
        CFG_IDX_COEF0:  coef_r[0*CFG_ROW_W +: CFG_ROW_W] <= cfg_wdata[CFG_ROW_W-1:0];
        CFG_IDX_COEF1:  coef_r[1*CFG_ROW_W +: CFG_ROW_W] <= cfg_wdata[CFG_ROW_W-1:0];
        CFG_IDX_COEF2:  coef_r[2*CFG_ROW_W +: CFG_ROW_W] <= cfg_wdata[CFG_ROW_W-1:0];
        CFG_IDX_COEF3:  coef_r[3*CFG_ROW_W +: CFG_ROW_W] <= cfg_wdata[CFG_ROW_W-1:0];
        CFG_IDX_COEF4:  coef_r[4*CFG_ROW_W +: CFG_ROW_W] <= cfg_wdata[CFG_ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (img_w_r == '0) begin
      w_eff = EW'(1);
    end else if (EW'(img_w_r) > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(img_w_r);
    end
    h_eff = (img_h_r == '0) ? CFG_IMG_H_W'(1) : img_h_r;
  end

  assign col_ext = EW'(col_r);
  assign col_inc = col_ext + EW'(1);
  assign row_inc = {1'b0, row_r} + (CFG_IMG_H_W + 1)'(1);
  assign emit    = (row_r >= CFG_IMG_H_W'(NUM_LINES)) && (col_ext >= EW'(NUM_LINES)) &&
                   (row_r < h_eff) && (col_ext < w_eff);
  assign last    = (row_r == h_eff - CFG_IMG_H_W'(1)) && (col_ext == w_eff - EW'(1));

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (col_inc >= w_eff) begin
      col_nxt = '0;
      row_nxt = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[CFG_IMG_H_W-1:0];
    end else begin
      col_nxt = col_inc[COL_W-1:0];
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign accept   = in_valid && en;
  assign s1_adv   = s1_valid_r && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      s2_tag_r   <= '0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (en) begin
        s1_valid_r     <= in_valid;
        s2_tag_r.valid <= s1_valid_r && s1_emit_r;
        s2_tag_r.last  <= s1_valid_r && s1_emit_r && s1_last_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px_r   <= {in_pixel_ch2, in_pixel_ch1, in_pixel_ch0};
      s1_col_r  <= col_r;
      s1_emit_r <= emit;
      s1_last_r <= last;
    end
  end

  rgbconv_line_buf #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (LB_W)
  ) u_line_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (col_r),
    .wr_en   (s1_adv),
    .wr_addr (s1_col_r),
    .wr_data (lb_wr_data),
    .rd_data (lb_rd_data)
  );

  // oldest line on top, current pixel at the bottom
  always_comb begin
    for (int m = 0; m < NUM_LINES; m++) begin
      newcol[m] = lb_rd_data[m*PX_W +: PX_W];
    end
    newcol[NUM_LINES] = s1_px_r;
    for (int m = 0; m < NUM_LINES; m++) begin
      lb_wr_data[m*PX_W +: PX_W] = newcol[m+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int m = 0; m < KERNEL_SIZE; m++) begin
        for (int n = 0; n < KERNEL_SIZE; n++) begin
          win_r[m][n] <= '0;
        end
      end
    end else if (s1_adv) begin
      for (int m = 0; m < KERNEL_SIZE; m++) begin
        for (int n = 0; n < KERNEL_SIZE - 1; n++) begin
          win_r[m][n] <= win_r[m][n+1];
        end
        win_r[m][KERNEL_SIZE-1] <= newcol[m];
      end
    end
  end

  always_comb begin
    for (int m = 0; m < KERNEL_SIZE; m++) begin
      for (int n = 0; n < KERNEL_SIZE; n++) begin
        win_flat[(m*KERNEL_SIZE+n)*PX_W +: PX_W] = win_r[m][n];
      end
    end
  end

  rgbconv_mac #(
    .KERNEL_SIZE (KERNEL_SIZE)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .tag_in    (s2_tag_r),
    .win       (win_flat),
    .coef      (coef_r),
    .out_valid (out_valid),
    .out_last  (out_last_of_frame),
    .sum_ch0   (out_sum_ch0),
    .sum_ch1   (out_sum_ch1),
    .sum_ch2   (out_sum_ch2),
    .sat_ch0   (out_sat_ch0),
    .sat_ch1   (out_sat_ch1),
    .sat_ch2   (out_sat_ch2)
  );

`ifndef NO_ASSERTIONS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

  a_last_needs_valid: assert property (@(posedge clk) disable iff (!rst_n)
    s2_tag_r.last |-> s2_tag_r.valid)
    else $error("frame end flagged on a pixel without result");
`endif

endmodule

// ----- tb/sv/rgb_image_convolution_top_test.sv -----
`timescale 1ns / 1ps

module rgb_image_convolution_top_test;
  import rgbconv_pkg::*;

  localparam int KS             = 3;
  localparam int MAX_W          = 1024;
  localparam int N_RANDOM       = 800;
  localparam int MIN_RESULTS    = 48;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 100;

  // scheduled phases ahead of the free random ones
  localparam int PH_WIDE    = 0;
  localparam int PH_TINY    = 1;
  localparam int PH_TALL    = 2;
  localparam int PH_NEG_SAT = 3;
  localparam int PH_POS_SAT = 4;
  localparam int PH_FREE    = 5;

  localparam logic [CFG_ROW_W-1:0] COEF_ALL_MIN = 40'h80_8080_8080;
  localparam logic [CFG_ROW_W-1:0] COEF_ALL_MAX = 40'h7F_7F7F_7F7F;
  localparam logic [CFG_ROW_W-1:0] LAPLACE_ROWS [MAX_K] =
    '{RST_COEF0, RST_COEF1, RST_COEF2, RST_COEF3, RST_COEF4};

  typedef enum {PIX_RANDOM, PIX_EXTREME, PIX_FULL, PIX_SMALL} pixel_mode_e;

  typedef struct packed {
    logic [SUM_W-1:0] sum0;
    logic [SUM_W-1:0] sum1;
    logic [SUM_W-1:0] sum2;
    logic [PIX_W-1:0] sat0;
    logic [PIX_W-1:0] sat1;
    logic [PIX_W-1:0] sat2;
    logic             last;
  } conv_result_t;

  typedef struct {
    pixel_t       px;
    bit           typed;
    conv_result_t res;
  } stim_row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [PIX_W-1:0]        in_pixel_ch0 = '0;
  logic [PIX_W-1:0]        in_pixel_ch1 = '0;
  logic [PIX_W-1:0]        in_pixel_ch2 = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [SUM_W-1:0] out_sum_ch0;
  logic signed [SUM_W-1:0] out_sum_ch1;
  logic signed [SUM_W-1:0] out_sum_ch2;
  logic [PIX_W-1:0]        out_sat_ch0;
  logic [PIX_W-1:0]        out_sat_ch1;
  logic [PIX_W-1:0]        out_sat_ch2;
  logic                    out_last_of_frame;
  logic                    cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_addr = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata = '0;

  // mirror of the block's registers and pixel state
  logic [CFG_IMG_W_W-1:0] img_w_reg = RST_IMG_W;
  logic [CFG_IMG_H_W-1:0] img_h_reg = RST_IMG_H;
  logic [CFG_ROW_W-1:0]   coef_reg [MAX_K] = LAPLACE_ROWS;
  bit   [PX_W-1:0]        line_mem [KS-1][MAX_W];
  bit   [PX_W-1:0]        win [KS][KS];
  int unsigned            col_cnt;
  int unsigned            row_cnt;

  conv_result_t filtered_q [$];
  int unsigned  results_predicted;
  int unsigned  fail_count;
  int unsigned  quiet_cycles;
  int unsigned  sink_hold;
  bit           src_burst;
  bit           sink_burst;

  // two 3x3 frames under the reset laplacian, result typed on each ninth pixel
  stim_row_t directed_rows [18] = '{
    '{24'hFF0000, 1'b0, '0}, '{24'hFFFF00, 1'b0, '0}, '{24'hFF0000, 1'b0, '0},
    '{24'hFFFF00, 1'b0, '0}, '{24'hFF00FF, 1'b0, '0}, '{24'hFFFF00, 1'b0, '0},
    '{24'hFF0000, 1'b0, '0}, '{24'hFFFF00, 1'b0, '0},
    '{24'hFF0000, 1'b1,
      '{21'd1020, -21'sd1020, 21'd0, 8'd255, 8'd0, 8'd0, 1'b1}},
    '{24'h010000, 1'b0, '0}, '{24'h010000, 1'b0, '0}, '{24'h010000, 1'b0, '0},
    '{24'h010000, 1'b0, '0}, '{24'h013F40, 1'b0, '0}, '{24'h010000, 1'b0, '0},
    '{24'h010000, 1'b0, '0}, '{24'h010000, 1'b0, '0},
    '{24'h010000, 1'b1,
      '{21'd256, 21'd252, 21'd0, 8'd255, 8'd252, 8'd0, 1'b1}}
  };

  rgb_image_convolution_top #(
    .KERNEL_SIZE(KS),
    .MAX_WIDTH  (MAX_W)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel_ch0     (in_pixel_ch0),
    .in_pixel_ch1     (in_pixel_ch1),
    .in_pixel_ch2     (in_pixel_ch2),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sum_ch0      (out_sum_ch0),
    .out_sum_ch1      (out_sum_ch1),
    .out_sum_ch2      (out_sum_ch2),
    .out_sat_ch0      (out_sat_ch0),
    .out_sat_ch1      (out_sat_ch1),
    .out_sat_ch2      (out_sat_ch2),
    .out_last_of_frame(out_last_of_frame),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int unsigned width_of(input logic [CFG_IMG_W_W-1:0] w);
    if (w == 0) return 1;
    if (w > MAX_W) return MAX_W;
    return w;
  endfunction

  function automatic int unsigned height_of(input logic [CFG_IMG_H_W-1:0] h);
    return (h == 0) ? 1 : h;
  endfunction

  function automatic logic [PIX_W-1:0] saturate(input int acc);
    if (acc < 0) return '0;
    if (acc > SAT_MAX) return SAT_MAX;
    return acc[PIX_W-1:0];
  endfunction

  function automatic bit filter_pixel(input pixel_t px, output conv_result_t res);
    int unsigned w, h, col;
    bit [PX_W-1:0] column [KS];
    int acc [NUM_CH];
    int m, n, c;
    bit hit;
    w = width_of(img_w_reg);
    h = height_of(img_h_reg);
    col = col_cnt % MAX_W;
    for (m = 0; m < KS - 1; m++) column[m] = line_mem[m][col];
    column[KS-1] = px;
    for (m = 0; m < KS - 1; m++) line_mem[m][col] = column[m+1];
    for (m = 0; m < KS; m++) begin
      for (n = 0; n < KS - 1; n++) win[m][n] = win[m][n+1];
      win[m][KS-1] = column[m];
    end
    hit = row_cnt >= KS - 1 && col_cnt >= KS - 1 && row_cnt < h && col_cnt < w;
    res = '0;
    if (hit) begin
      for (c = 0; c < NUM_CH; c++) begin
        acc[c] = 0;
        for (m = 0; m < KS; m++) begin
          for (n = 0; n < KS; n++) begin
            acc[c] += int'(win[m][n][PIX_W*c +: PIX_W]) *
                      int'($signed(coef_reg[m][COEF_W*n +: COEF_W]));
          end
        end
      end
      res.sum0 = acc[0][SUM_W-1:0];
      res.sum1 = acc[1][SUM_W-1:0];
      res.sum2 = acc[2][SUM_W-1:0];
      res.sat0 = saturate(acc[0]);
      res.sat1 = saturate(acc[1]);
      res.sat2 = saturate(acc[2]);
      res.last = (row_cnt == h - 1) && (col_cnt == w - 1);
      results_predicted++;
    end
    col_cnt++;
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
      if (row_cnt >= h) row_cnt = 0;
    end
    return hit;
  endfunction

  function automatic int unsigned frame_remaining();
    int unsigned w, h, rest;
    w = width_of(img_w_reg);
    h = height_of(img_h_reg);
    rest = (col_cnt >= w) ? 1 : w - col_cnt;
    if (row_cnt + 1 < h) rest += (h - row_cnt - 1) * w;
    return rest;
  endfunction

  function automatic pixel_t draw_pixel(input pixel_mode_e mode);
    pixel_t px;
    int c;
    px = $urandom;
    for (c = 0; c < NUM_CH; c++) begin
      case (mode)
        PIX_EXTREME: px[PIX_W*c +: PIX_W] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        PIX_FULL:    px[PIX_W*c +: PIX_W] = 8'hFF;
        PIX_SMALL:   px[PIX_W*c +: PIX_W] = $urandom_range(0, 3);
        default: ;
      endcase
    end
    return px;
  endfunction

  function automatic logic [CFG_ROW_W-1:0] draw_coef_row();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      1: return COEF_ALL_MIN;
      2: return COEF_ALL_MAX;
      3: return RST_COEF1;
      4: return '0;
      default: return bits[CFG_ROW_W-1:0];
    endcase
  endfunction

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS)
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_IDX_WIDTH:  img_w_reg = val[CFG_IMG_W_W-1:0];
      CFG_IDX_HEIGHT: img_h_reg = val[CFG_IMG_H_W-1:0];
      CFG_IDX_COEF0, CFG_IDX_COEF1, CFG_IDX_COEF2, CFG_IDX_COEF3, CFG_IDX_COEF4:
        coef_reg[idx - CFG_IDX_COEF0] = val[CFG_ROW_W-1:0];
      default: ;
    endcase
  endtask

  task automatic send_pixel(input pixel_t px, input bit typed, input conv_result_t typed_res);
    conv_result_t res;
    int gap;
    if ($urandom_range(0, 31) == 0) src_burst = !src_burst;
    gap = src_burst ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_pixel_ch0 <= px[7:0];
    in_pixel_ch1 <= px[15:8];
    in_pixel_ch2 <= px[23:16];
    do @(posedge clk); while (!in_ready);
    if (filter_pixel(px, res)) filtered_q.push_back(typed ? typed_res : res);
  endtask

  task automatic wait_idle();
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // result side: compare every accepted result, then a random hold-off
  always @(posedge clk) begin
    conv_result_t want;
    int unsigned draw;
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_hold <= 0;
    end else if (out_valid && out_ready) begin
      if (filtered_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: result expected none, actual sums %0d %0d %0d", $time,
                   out_sum_ch0, out_sum_ch1, out_sum_ch2);
      end else begin
        want = filtered_q.pop_front();
        compare_field("sum_ch0", $signed(want.sum0), out_sum_ch0);
        compare_field("sum_ch1", $signed(want.sum1), out_sum_ch1);
        compare_field("sum_ch2", $signed(want.sum2), out_sum_ch2);
        compare_field("sat_ch0", want.sat0, out_sat_ch0);
        compare_field("sat_ch1", want.sat1, out_sat_ch1);
        compare_field("sat_ch2", want.sat2, out_sat_ch2);
        compare_field("last_of_frame", want.last, out_last_of_frame);
      end
      if ($urandom_range(0, 31) == 0) sink_burst = !sink_burst;
      draw = sink_burst ? 0 : $urandom_range(0, 13);
      sink_hold <= draw;
      out_ready <= (draw == 0);
    end else if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      out_ready <= (sink_hold == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned new_w, new_h, n_items, extra, free_items;
    pixel_mode_e mode;
    int phase, r, k;
    free_items = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    cfg_write(CFG_IDX_WIDTH, 3);
    cfg_write(CFG_IDX_HEIGHT, 3);
    cfg_we <= 1'b0;
    foreach (directed_rows[i])
      send_pixel(directed_rows[i].px, directed_rows[i].typed, directed_rows[i].res);
    in_valid <= 1'b0;

    phase = 0;
    while (phase < PH_FREE || free_items < N_RANDOM || results_predicted < MIN_RESULTS) begin
      wait_idle();
      new_w = $urandom_range(0, 12);
      new_h = $urandom_range(0, 8);
      mode  = pixel_mode_e'($urandom_range(0, 3));
      case (phase)
        PH_WIDE: begin
          new_w = 2047;
          new_h = 3;
          mode  = PIX_RANDOM;
        end
        PH_TINY: begin
          new_w = 0;
          new_h = 0;
        end
        PH_TALL: begin
          new_w = 6;
          new_h = 16'hFFFF;
        end
        PH_NEG_SAT: begin
          new_w = 4;
          new_h = 4;
          mode  = PIX_FULL;
        end
        PH_POS_SAT: begin
          new_w = 5;
          new_h = 3;
          mode  = PIX_FULL;
        end
        default: ;
      endcase
      // mid-frame the line may not grow past columns already stored
      if ((col_cnt != 0 || row_cnt != 0) && width_of(new_w) > width_of(img_w_reg))
        new_w = img_w_reg;
      cfg_write(CFG_IDX_WIDTH, new_w);
      cfg_write(CFG_IDX_HEIGHT, new_h);
      for (r = 0; r < MAX_K; r++) begin
        case (phase)
          PH_TALL:    cfg_write(CFG_IDX_COEF0 + r, LAPLACE_ROWS[r]);
          PH_NEG_SAT: cfg_write(CFG_IDX_COEF0 + r, COEF_ALL_MIN);
          PH_POS_SAT: cfg_write(CFG_IDX_COEF0 + r, COEF_ALL_MAX);
          default: if ($urandom_range(0, 1)) cfg_write(CFG_IDX_COEF0 + r, draw_coef_row());
        endcase
      end
      cfg_we <= 1'b0;

      extra   = (phase == PH_WIDE) ? 0 : $urandom_range(phase < PH_FREE ? 1 : 0, 2);
      n_items = frame_remaining() + extra * width_of(img_w_reg) * height_of(img_h_reg);
      if (phase == PH_TALL)
        n_items = 6 * 5 + 3;
      else if (phase >= PH_FREE && $urandom_range(0, 4) == 0)
        n_items = $urandom_range(1, frame_remaining());
      for (k = 0; k < n_items; k++) send_pixel(draw_pixel(mode), 1'b0, '0);
      in_valid <= 1'b0;
      if (phase >= PH_FREE) free_items += n_items;
      phase++;
    end

    wait_idle();
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
